[rtl/core/plrt_pkg.sv]
package plrt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [7:0] DFLT_ECHO_HI     = 8'd16;
    localparam logic [7:0] DFLT_ANN_LO      = 8'd4;
    localparam logic [7:0] DFLT_ANN_HI      = 8'd32;
    localparam logic [7:0] DFLT_ELEC_LO     = 8'd8;
    localparam logic [7:0] DFLT_ELEC_HI     = 8'd16;
    localparam logic [7:0] DFLT_DIE_HI      = 8'd8;
    localparam logic [7:0] ELECTION_MIN_LEN = 8'd6;

    localparam logic [2:0] DFLT_ECHO  = 3'd0;
    localparam logic [2:0] DFLT_ANN   = 3'd1;
    localparam logic [2:0] DFLT_ELEC  = 3'd2;
    localparam logic [2:0] DFLT_REKEY = 3'd3;
    localparam logic [2:0] DFLT_DIE   = 3'd4;

    typedef enum logic [0:0] {
        OP_VALIDATE = 1'b0,
        OP_REGISTER = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_ECHO      = 3'd0,
        CFG_ANNOUNCE  = 3'd1,
        CFG_ELECTION  = 3'd2,
        CFG_REKEY     = 3'd3,
        CFG_DIE       = 3'd4,
        CFG_REKEY_LEN = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_VALIDATE = 2'd0,
        K_REGISTER = 2'd1,
        K_APPEND   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ISSUE,
        S_RUN,
        S_DELIVER
    } t_state;

    typedef struct packed {
        logic       opcode;
        logic [7:0] message_type;
        logic [7:0] payload_length;
        logic       payload_present;
        logic [7:0] rule_min;
        logic [7:0] rule_max;
        logic       rule_fixed;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] invalid_total;
    } t_out;

    typedef struct packed {
        logic [7:0] echo_type;
        logic [7:0] announce_type;
        logic [7:0] election_type;
        logic [7:0] rekey_type;
        logic [7:0] die_type;
        logic [7:0] rekey_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] mtype;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       fixed;
    } t_entry;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        t_entry           rule;
        logic [7:0]       len;
        logic             present;
        logic [CNT_W-1:0] remaining;
        logic             found;
        logic             len_ok;
        logic             grow;
    } t_tok;

    function automatic t_entry default_rule(input logic [2:0] k, input t_cfg cfg);
        t_entry e;
        e = '0;
        unique case (k)
            DFLT_ECHO: begin
                e = '{mtype: cfg.echo_type, lo: 8'd0, hi: DFLT_ECHO_HI, fixed: 1'b0};
            end
            DFLT_ANN: begin
                e = '{mtype: cfg.announce_type, lo: DFLT_ANN_LO, hi: DFLT_ANN_HI,
                      fixed: 1'b0};
            end
            DFLT_ELEC: begin
                e = '{mtype: cfg.election_type, lo: DFLT_ELEC_LO, hi: DFLT_ELEC_HI,
                      fixed: 1'b0};
            end
            DFLT_REKEY: begin
                e = '{mtype: cfg.rekey_type, lo: cfg.rekey_length, hi: cfg.rekey_length,
                      fixed: 1'b1};
            end
            DFLT_DIE: begin
                e = '{mtype: cfg.die_type, lo: 8'd0, hi: DFLT_DIE_HI, fixed: 1'b0};
            end
            default: begin
                e = '0;
            end
        endcase
        return e;
    endfunction

endpackage

[rtl/core/plrt_cell.sv]
module plrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  plrt_pkg::t_tok i_tok,
    output plrt_pkg::t_tok o_tok
);
    import plrt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_tok   r_tok;
    t_tok   n_tok;

    logic here;
    logic active;
    logic match;

    assign here   = (i_tok.remaining != '0);
    assign active = i_tok.valid && !i_tok.found;
    assign match  = here && (r_entry.mtype == i_tok.rule.mtype);

    always_comb begin
        n_tok   = i_tok;
        n_entry = r_entry;
        if (here) begin
            n_tok.remaining = i_tok.remaining - CNT_W'(1);
        end
        if (active) begin
            unique case (i_tok.kind)
                K_VALIDATE: begin
                    if (match) begin
                        n_tok.found = 1'b1;
                        if (r_entry.fixed) begin
                            n_tok.len_ok = (i_tok.len == r_entry.lo);
                        end else begin
                            n_tok.len_ok = (i_tok.len >= r_entry.lo) &&
                                           (i_tok.len <= r_entry.hi);
                        end
                    end
                end
                K_REGISTER: begin
                    if (match) begin
                        n_tok.found   = 1'b1;
                        n_entry.lo    = i_tok.rule.lo;
                        n_entry.hi    = i_tok.rule.hi;
                        n_entry.fixed = i_tok.rule.fixed;
                    end else if (!here) begin
                        n_tok.found = 1'b1;
                        n_tok.grow  = 1'b1;
                        n_entry     = i_tok.rule;
                    end
                end
                K_APPEND: begin
                    if (!here) begin
                        n_tok.found = 1'b1;
                        n_entry     = i_tok.rule;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[rtl/core/plrt_ctrl.sv]
module plrt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plrt_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  plrt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output plrt_pkg::t_out o_out_data,
    output plrt_pkg::t_tok o_tok,
    input  plrt_pkg::t_tok i_tok
);
    import plrt_pkg::*;

    t_state           r_state;
    t_state           n_state;
    t_in              r_item;
    logic [CNT_W-1:0] r_count;
    logic             r_loaded;
    logic [2:0]       r_k;
    logic [31:0]      r_rejects;
    t_out             r_res;
    logic             r_out_valid;
    t_out             r_out;

    logic    in_fire;
    logic    table_full;
    logic    tail_done;
    logic    out_free;
    t_status end_status;

    assign in_fire    = i_in_valid && o_in_ready;
    assign table_full = (r_count >= CNT_W'(TABLE_DEPTH));
    assign tail_done  = i_tok.valid && (i_tok.kind != K_APPEND);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        end_status = ST_OK;
        if (i_tok.kind == K_VALIDATE && i_tok.found) begin
            if (!i_tok.len_ok) begin
                end_status = ST_INVALID;
            end else if (i_tok.rule.mtype == i_cfg.rekey_type) begin
                end_status = i_tok.present ? ST_OK : ST_INVALID;
            end else if (i_tok.rule.mtype == i_cfg.election_type) begin
                end_status = (i_tok.len >= ELECTION_MIN_LEN) ? ST_OK : ST_INVALID;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.opcode == OP_REGISTER && table_full) begin
                        n_state = S_DELIVER;
                    end else if (i_in_data.opcode == OP_VALIDATE && !r_loaded) begin
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_LOAD: begin
                if (r_k == DFLT_DIE) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (tail_done) begin
                    n_state = S_DELIVER;
                end
            end
            S_DELIVER: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_tok      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_LOAD: begin
                o_tok.valid     = !table_full;
                o_tok.kind      = K_APPEND;
                o_tok.rule      = default_rule(r_k, i_cfg);
                o_tok.remaining = r_count;
            end
            S_ISSUE: begin
                o_tok.valid      = 1'b1;
                o_tok.kind       = (r_item.opcode == OP_REGISTER) ? K_REGISTER : K_VALIDATE;
                o_tok.rule.mtype = r_item.message_type;
                o_tok.rule.lo    = r_item.rule_min;
                o_tok.rule.hi    = r_item.rule_max;
                o_tok.rule.fixed = r_item.rule_fixed;
                o_tok.len        = r_item.payload_length;
                o_tok.present    = r_item.payload_present;
                o_tok.remaining  = r_count;
            end
            S_RUN, S_DELIVER: begin
                o_tok = '0;
            end
            default: begin
                o_tok = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
        if (r_state == S_IDLE && in_fire) begin
            r_res <= '{status: ST_FULL, invalid_total: r_rejects};
        end else if (r_state == S_RUN && tail_done) begin
            r_res.status        <= end_status;
            r_res.invalid_total <= (end_status == ST_INVALID) ? r_rejects + 32'd1
                                                               : r_rejects;
        end
        if (r_state == S_DELIVER && out_free) begin
            r_out <= r_res;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_loaded    <= 1'b0;
            r_k         <= '0;
            r_rejects   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && in_fire && n_state == S_LOAD) begin
                r_loaded <= 1'b1;
                r_k      <= DFLT_ECHO;
            end
            if (r_state == S_LOAD) begin
                r_k <= r_k + 3'd1;
                if (!table_full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (r_state == S_RUN && tail_done) begin
                if (i_tok.grow) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (end_status == ST_INVALID) begin
                    r_rejects <= r_rejects + 32'd1;
                end
            end
            if (r_state == S_DELIVER && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("rule count past table depth");

    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_done |-> r_state == S_RUN)
        else $error("transaction left the chain outside run");

    a_loaded_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_loaded))
        else $error("defaults flag cleared");

    a_grow_only_register: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tok.valid && i_tok.grow) |-> i_tok.kind == K_REGISTER)
        else $error("table grew from a non-register transaction");

endmodule

[rtl/core/payload_length_rule_table.sv]
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------
// in        | input     | i_in_valid / o_in_ready    | i_in_data (t_in)
// out       | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
// cfg       | input     | i_cfg_we, no wait          | i_cfg_idx, i_cfg_data
//
// a transaction walks the chain of TABLE_DEPTH rule cells, one cell a cycle; the first
// validate first loads the default rules into the table, and a register refused on a
// full table skips the chain and goes straight to delivery.
// reset is synchronous, active low; the rule cells hold garbage until written.
// a new transaction is taken while the previous result still waits in the output
// register; a stalled output only holds the controller in delivery.
module payload_length_rule_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  plrt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output plrt_pkg::t_out o_out_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data
);
    import plrt_pkg::*;

    t_cfg r_cfg;
    t_tok w_tok [0:TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{echo_type: 8'd0, announce_type: 8'd1, election_type: 8'd2,
                       rekey_type: 8'd3, die_type: 8'd4, rekey_length: 8'd48};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ECHO:      r_cfg.echo_type     <= i_cfg_data;
                CFG_ANNOUNCE:  r_cfg.announce_type <= i_cfg_data;
                CFG_ELECTION:  r_cfg.election_type <= i_cfg_data;
                CFG_REKEY:     r_cfg.rekey_type    <= i_cfg_data;
                CFG_DIE:       r_cfg.die_type      <= i_cfg_data;
                CFG_REKEY_LEN: r_cfg.rekey_length  <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    plrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_tok       (w_tok[0]),
        .i_tok       (w_tok[TABLE_DEPTH])
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        plrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule

[tb/plrt_rule_checker.sv]
module plrt_rule_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  plrt_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  plrt_pkg::t_out i_out_data,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_checked,
    output int             o_rejected
);
    timeunit 1ns;
    timeprecision 1ps;
    import plrt_pkg::*;

    t_entry      rules [TABLE_DEPTH];
    int          rule_total;
    logic        defaults_in;
    logic [31:0] reject_tally;
    t_cfg        cfg;
    t_out        pending_verdicts [$];

    function automatic void add_rule(input t_entry e);
        if (rule_total < TABLE_DEPTH) begin
            rules[rule_total] = e;
            rule_total++;
        end
    endfunction

    function automatic t_status check_payload(input t_in req);
        t_status verdict;
        logic    hit;
        logic    ok;
        verdict = ST_OK;
        hit = 1'b0;
        if (!defaults_in) begin
            add_rule('{mtype: cfg.echo_type, lo: 8'd0, hi: DFLT_ECHO_HI, fixed: 1'b0});
            add_rule('{mtype: cfg.announce_type, lo: DFLT_ANN_LO, hi: DFLT_ANN_HI,
                       fixed: 1'b0});
            add_rule('{mtype: cfg.election_type, lo: DFLT_ELEC_LO, hi: DFLT_ELEC_HI,
                       fixed: 1'b0});
            add_rule('{mtype: cfg.rekey_type, lo: cfg.rekey_length, hi: cfg.rekey_length,
                       fixed: 1'b1});
            add_rule('{mtype: cfg.die_type, lo: 8'd0, hi: DFLT_DIE_HI, fixed: 1'b0});
            defaults_in = 1'b1;
        end
        for (int i = 0; i < rule_total; i++) begin
            if (!hit && rules[i].mtype == req.message_type) begin
                hit = 1'b1;
                if (rules[i].fixed) begin
                    ok = (req.payload_length == rules[i].lo);
                end else begin
                    ok = (req.payload_length >= rules[i].lo) &&
                         (req.payload_length <= rules[i].hi);
                end
                // rekey check wins when both codes are equal
                if (ok) begin
                    if (req.message_type == cfg.rekey_type) begin
                        ok = req.payload_present;
                    end else if (req.message_type == cfg.election_type) begin
                        ok = (req.payload_length >= ELECTION_MIN_LEN);
                    end
                end
                verdict = ok ? ST_OK : ST_INVALID;
            end
        end
        return verdict;
    endfunction

    function automatic t_status store_rule(input t_in req);
        if (rule_total >= TABLE_DEPTH) begin
            return ST_FULL;
        end
        for (int i = 0; i < rule_total; i++) begin
            if (rules[i].mtype == req.message_type) begin
                rules[i].lo = req.rule_min;
                rules[i].hi = req.rule_max;
                rules[i].fixed = req.rule_fixed;
                return ST_OK;
            end
        end
        add_rule('{mtype: req.message_type, lo: req.rule_min, hi: req.rule_max,
                   fixed: req.rule_fixed});
        return ST_OK;
    endfunction

    function automatic t_out rule_verdict(input t_in req);
        t_out result;
        if (req.opcode == OP_VALIDATE) begin
            result.status = check_payload(req);
            if (result.status == ST_INVALID) begin
                reject_tally++;
            end
        end else begin
            result.status = store_rule(req);
        end
        result.invalid_total = reject_tally;
        return result;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        o_errors++;
        if (o_errors <= 10) begin
            $display("mismatch in %s at transaction %0d: expected 0x%0h, got 0x%0h",
                     field, o_checked, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pending_verdicts.delete();
            rule_total = 0;
            defaults_in = 1'b0;
            reject_tally = '0;
            cfg = '{echo_type: 8'd0, announce_type: 8'd1, election_type: 8'd2,
                    rekey_type: 8'd3, die_type: 8'd4, rekey_length: 8'd48};
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ECHO:      cfg.echo_type = i_cfg_data;
                    CFG_ANNOUNCE:  cfg.announce_type = i_cfg_data;
                    CFG_ELECTION:  cfg.election_type = i_cfg_data;
                    CFG_REKEY:     cfg.rekey_type = i_cfg_data;
                    CFG_DIE:       cfg.die_type = i_cfg_data;
                    CFG_REKEY_LEN: cfg.rekey_length = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (i_out_data.status == ST_INVALID) begin
                    o_rejected++;
                end
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch("result with nothing pending", '0,
                                  {30'd0, i_out_data.status});
                end else begin
                    want = pending_verdicts.pop_front();
                    if (want.status !== i_out_data.status) begin
                        flag_mismatch("status", {30'd0, want.status},
                                      {30'd0, i_out_data.status});
                    end
                    if (want.invalid_total !== i_out_data.invalid_total) begin
                        flag_mismatch("invalid_total", want.invalid_total,
                                      i_out_data.invalid_total);
                    end
                end
                o_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                pending_verdicts.push_back(rule_verdict(i_in_data));
            end
            o_pending <= pending_verdicts.size();
        end
    end

endmodule

[tb/payload_length_rule_table_tb.sv]
module payload_length_rule_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import plrt_pkg::*;

    localparam int RUN_LIMIT = 800000;
    localparam int PHASE_ITEMS = 205;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in        in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out       out_data;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic [7:0] cfg_data;
    bit         idle_on = 1'b1;
    int         errors;
    int         pending;
    int         checked;
    int         rejected;
    int         cycles;
    logic [7:0] known_types [$];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    payload_length_rule_table dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    plrt_rule_checker rule_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_rejected (rejected)
    );

    always @(posedge clk) begin
        out_ready <= !idle_on || ($urandom_range(0, 99) >= 20);
    end

    task automatic send_request(input t_in req);
        if (idle_on && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic ask_validate(input logic [7:0] mtype, input logic [7:0] len,
                                input logic present);
        t_in req;
        req.opcode = OP_VALIDATE;
        req.message_type = mtype;
        req.payload_length = len;
        req.payload_present = present;
        req.rule_min = 8'($urandom);
        req.rule_max = 8'($urandom);
        req.rule_fixed = 1'($urandom);
        send_request(req);
    endtask

    task automatic ask_register(input logic [7:0] mtype, input logic [7:0] lo,
                                input logic [7:0] hi, input logic fixed);
        t_in req;
        req.opcode = OP_REGISTER;
        req.message_type = mtype;
        req.payload_length = 8'($urandom);
        req.payload_present = 1'($urandom);
        req.rule_min = lo;
        req.rule_max = hi;
        req.rule_fixed = fixed;
        send_request(req);
    endtask

    function automatic logic [7:0] pick_type();
        if ($urandom_range(0, 99) < 70) begin
            return known_types[$urandom_range(0, known_types.size() - 1)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_request();
        t_in req;
        req.opcode = ($urandom_range(0, 99) < 12) ? OP_REGISTER : OP_VALIDATE;
        req.message_type = pick_type();
        req.payload_length = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 48)) :
                                                           8'($urandom_range(0, 255));
        req.payload_present = ($urandom_range(0, 99) < 85);
        req.rule_min = 8'($urandom);
        req.rule_max = 8'($urandom);
        req.rule_fixed = 1'($urandom);
        send_request(req);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_setting(input t_cfg_idx idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic [7:0] echo_code, input logic [7:0] ann_code,
                                  input logic [7:0] elec_code, input logic [7:0] rekey_code,
                                  input logic [7:0] die_code, input logic [7:0] rekey_len);
        write_setting(CFG_ECHO, echo_code);
        write_setting(CFG_ANNOUNCE, ann_code);
        write_setting(CFG_ELECTION, elec_code);
        write_setting(CFG_REKEY, rekey_code);
        write_setting(CFG_DIE, die_code);
        write_setting(CFG_REKEY_LEN, rekey_len);
    endtask

    task automatic run_phase(input logic [7:0] echo_code, input logic [7:0] ann_code,
                             input logic [7:0] elec_code, input logic [7:0] rekey_code,
                             input logic [7:0] die_code, input logic [7:0] rekey_len,
                             input bit with_idle);
        wait_drained();
        write_settings(echo_code, ann_code, elec_code, rekey_code, die_code, rekey_len);
        idle_on <= with_idle;
        repeat (PHASE_ITEMS) random_request();
    endtask

    initial begin
        for (cycles = 0; cycles < RUN_LIMIT; cycles++) @(posedge clk);
        $display("payload_length_rule_table_tb: done, errors");
        $finish;
    end

    initial begin
        bit [255:0] seen;
        int         distinct;
        logic [7:0] mtype;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_settings(8'h00, 8'hFF, 8'h02, 8'h03, 8'h04, 8'hFF);

        // rules registered before any validate, so defaults land at the tail
        ask_register(8'hFE, 8'h00, 8'hFF, 1'b0);
        ask_register(8'hFD, 8'hFF, 8'h00, 1'b1);
        ask_register(8'hFC, 8'd10, 8'd20, 1'b0);
        ask_register(8'hFC, 8'd30, 8'd40, 1'b0);
        known_types = '{8'hFC, 8'hFD, 8'hFE};
        seen = '0;
        seen[8'hFC] = 1'b1;
        seen[8'hFD] = 1'b1;
        seen[8'hFE] = 1'b1;
        distinct = 3;

        // crowd the table so only four defaults fit and the die rule is dropped
        while (distinct < TABLE_DEPTH - 4) begin
            if (known_types.size() > 3 && $urandom_range(0, 99) < 25) begin
                mtype = known_types[$urandom_range(3, known_types.size() - 1)];
            end else begin
                mtype = 8'($urandom_range(8'h20, 8'h9F));
            end
            ask_register(mtype, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
            if (!seen[mtype]) begin
                seen[mtype] = 1'b1;
                known_types.push_back(mtype);
                distinct++;
            end
        end

        ask_validate(8'hFC, 8'd29, 1'b1);
        ask_validate(8'hFC, 8'd30, 1'b0);
        ask_validate(8'hFC, 8'd40, 1'b1);
        ask_validate(8'hFC, 8'd41, 1'b1);
        ask_validate(8'hFD, 8'hFF, 1'b1);
        ask_validate(8'hFD, 8'h00, 1'b1);
        ask_validate(8'hFE, 8'hFF, 1'b0);
        ask_validate(8'h00, 8'd16, 1'b1);
        ask_validate(8'h00, 8'd17, 1'b1);
        ask_validate(8'hFF, 8'd3, 1'b1);
        ask_validate(8'hFF, 8'd4, 1'b1);
        ask_validate(8'hFF, 8'd32, 1'b1);
        ask_validate(8'hFF, 8'd33, 1'b1);
        ask_validate(8'h02, 8'd7, 1'b1);
        ask_validate(8'h02, 8'd8, 1'b1);
        ask_validate(8'h02, 8'd16, 1'b1);
        ask_validate(8'h02, 8'd17, 1'b1);
        ask_validate(8'h03, 8'hFF, 1'b1);
        ask_validate(8'h03, 8'hFF, 1'b0);
        ask_validate(8'h03, 8'hFE, 1'b1);
        ask_validate(8'h04, 8'h00, 1'b1);
        ask_validate(8'h01, 8'h80, 1'b0);
        // full table refuses both an update and a new type
        ask_register(8'hFC, 8'h00, 8'hFF, 1'b0);
        ask_register(8'h01, 8'h00, 8'hFF, 1'b1);

        known_types.push_back(8'h00);
        known_types.push_back(8'hFF);
        known_types.push_back(8'h02);
        known_types.push_back(8'h03);
        known_types.push_back(8'h04);
        known_types.push_back(8'h01);

        run_phase(8'h5A, 8'h11, 8'hFE, 8'h03, 8'h44, 8'h00, 1'b1);
        run_phase(8'h13, 8'h22, 8'hFE, 8'hFE, 8'h55, 8'h30, 1'b1);
        run_phase(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 1'b0);
        run_phase(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        run_phase(8'($urandom), 8'($urandom), pick_type(), pick_type(), 8'($urandom),
                  8'($urandom), 1'b1);

        wait_drained();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        $display("%0d transactions checked over six register settings on a full table",
                 checked);
        $display("%0d payloads rejected, %0d mismatches", rejected, errors);
        if (errors == 0 && pending == 0) begin
            $display("payload_length_rule_table_tb: done, clean");
        end else begin
            $display("payload_length_rule_table_tb: done, errors");
        end
        $finish;
    end

endmodule
